// ===== design/vcl_pkg.sv =====
// Shared types, constants and the sine table generator for the L1 Voronoi
// color lookup core. No dependencies.
package vcl_pkg;

  localparam int MAX_SEEDS_DEF    = 128;
  localparam int SINE_ENTRIES_DEF = 256;
  localparam int QDEPTH           = 2;
  localparam int SIN_W            = 10;
  localparam int DIST_W           = 19;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [3:0] CFG_BOX_MIN_X  = 4'd0;
  localparam logic [3:0] CFG_BOX_MAX_X  = 4'd1;
  localparam logic [3:0] CFG_BOX_MIN_Y  = 4'd2;
  localparam logic [3:0] CFG_BOX_MAX_Y  = 4'd3;
  localparam logic [3:0] CFG_BOX_MIN_Z  = 4'd4;
  localparam logic [3:0] CFG_BOX_MAX_Z  = 4'd5;
  localparam logic [3:0] CFG_NOISE_RATE = 4'd6;
  localparam logic [3:0] CFG_SEED_COUNT = 4'd7;

  localparam logic signed [13:0] OUTSIDE_COLOR = 14'sd4096;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam longint unsigned A1 = 64'd26353589;
  localparam longint unsigned A3 = 64'd10837479;
  localparam longint unsigned A5 = 64'd1337020;
  localparam longint unsigned A7 = 64'd78547;

  typedef struct packed {
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_y;
    logic signed [15:0] box_min_z;
    logic signed [15:0] box_max_z;
    logic [15:0]        noise_rate;
    logic [7:0]         seed_count;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [6:0]         slot;
    logic [11:0]        seed_red;
    logic [11:0]        seed_green;
    logic [11:0]        seed_blue;
    logic               in_box;
    logic [15:0]        ph_x;
    logic [15:0]        ph_y;
    logic [15:0]        ph_z;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // 0.1*sin in Q12 for an angle t in 1/65536 turns; elaboration only.
  function automatic logic signed [SIN_W-1:0] sine_value(input longint unsigned t);
    longint unsigned q;
    longint unsigned r;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned s;
    longint          v;
    q  = (t >> 14) & 64'd3;
    r  = t & 64'd16383;
    z  = q[0] ? (64'd16384 - r) : r;
    z2 = (z * z + 64'd8192) >> 14;
    p  = A7;
    p  = A5 - ((p * z2) >> 14);
    p  = A3 - ((p * z2) >> 14);
    p  = A1 - ((p * z2) >> 14);
    s  = (p * z) >> 14;
    v  = longint'((s + 64'd20480) / 64'd40960);
    if (q[1]) begin
      v = -v;
    end
    return SIN_W'(v);
  endfunction

endpackage

// ===== design/voronoi_l1_cell_color_lookup_core.sv =====
// L1 Voronoi cell color lookup core. A load is written to the seed tables; a query
// inside the box scans n seeds (n = clamped seed_count), one outside skips the scan.
// Throughput: one load per cycle while the back end is idle; during a query the back
// end takes no item until the result is in the output register, as the scan reads
// the seed coordinate memory once per seed. rst_n (synchronous) resets control and
// sets the config registers to defaults; seed tables are undefined until loaded.
module voronoi_l1_cell_color_lookup_core #(
  parameter int MAX_SEEDS    = vcl_pkg::MAX_SEEDS_DEF,
  parameter int SINE_ENTRIES = vcl_pkg::SINE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], slot[54:48], seed_red[66:55],
  // seed_green[78:67], seed_blue[90:79], zero pad[95:91]
  input  logic [95:0] in_tdata,
  // kind[0]: 0 load seed, 1 query
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // nearest[6:0], out_red[20:7], out_green[34:21], out_blue[48:35], zero pad[55:49]
  output logic [55:0] out_tdata,
  // inside_res[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vcl_pkg::cfg_t    cfg_r;
  vcl_pkg::q_stat_t q_stat;
  vcl_pkg::item_t   push_item;
  vcl_pkg::item_t   head;
  logic             push;
  logic             pop;

  // Config writes are always taken; the user writes only while the core is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_min_x  <= 16'sd0;
      cfg_r.box_max_x  <= 16'sd256;
      cfg_r.box_min_y  <= 16'sd0;
      cfg_r.box_max_y  <= 16'sd256;
      cfg_r.box_min_z  <= 16'sd0;
      cfg_r.box_max_z  <= 16'sd256;
      cfg_r.noise_rate <= 16'd4096;
      cfg_r.seed_count <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vcl_pkg::CFG_BOX_MIN_X:  cfg_r.box_min_x  <= cfg_data;
        vcl_pkg::CFG_BOX_MAX_X:  cfg_r.box_max_x  <= cfg_data;
        vcl_pkg::CFG_BOX_MIN_Y:  cfg_r.box_min_y  <= cfg_data;
        vcl_pkg::CFG_BOX_MAX_Y:  cfg_r.box_max_y  <= cfg_data;
        vcl_pkg::CFG_BOX_MIN_Z:  cfg_r.box_min_z  <= cfg_data;
        vcl_pkg::CFG_BOX_MAX_Z:  cfg_r.box_max_z  <= cfg_data;
        vcl_pkg::CFG_NOISE_RATE: cfg_r.noise_rate <= cfg_data;
        vcl_pkg::CFG_SEED_COUNT: cfg_r.seed_count <= cfg_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: stage the item, test the box, form noise phases.
  vcl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: lets loads pile up while a query scan runs.
  vcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: write seeds, scan one seed a cycle, add noise, hold the result.
  vcl_back #(
    .MAX_SEEDS    (MAX_SEEDS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // An outside result carries nearest 0 and white on every channel.
  a_outside_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[6:0] == 7'd0 && out_tdata[20:7] == vcl_pkg::OUTSIDE_COLOR &&
      out_tdata[34:21] == vcl_pkg::OUTSIDE_COLOR &&
      out_tdata[48:35] == vcl_pkg::OUTSIDE_COLOR)
    else $error("outside result is not white");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue overflow");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

// ===== design/vcl_front.sv =====
// Front end: registers input items, tests the box and forms noise phases.
// Depends on vcl_pkg.
module vcl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [95:0]      in_tdata,
  input  logic [0:0]       in_tuser,
  input  vcl_pkg::cfg_t    cfg,
  input  vcl_pkg::q_stat_t q_stat,
  output logic             push,
  output vcl_pkg::item_t   push_item
);

  logic               stg_valid_r;
  logic               stg_kind_r;
  logic signed [15:0] stg_x_r;
  logic signed [15:0] stg_y_r;
  logic signed [15:0] stg_z_r;
  logic [6:0]         stg_slot_r;
  logic [35:0]        stg_color_r;
  logic               accept;
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;
  logic signed [32:0] prod_z;
  logic               in_box;

  assign push      = stg_valid_r && !q_stat.full;
  assign in_tready = !stg_valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (accept) begin
      stg_valid_r <= 1'b1;
    end else if (push) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_kind_r  <= in_tuser[0];
      stg_x_r     <= in_tdata[15:0];
      stg_y_r     <= in_tdata[31:16];
      stg_z_r     <= in_tdata[47:32];
      stg_slot_r  <= in_tdata[54:48];
      stg_color_r <= in_tdata[90:55];
    end
  end

  assign prod_x = $signed({1'b0, cfg.noise_rate}) * stg_x_r;
  assign prod_y = $signed({1'b0, cfg.noise_rate}) * stg_y_r;
  assign prod_z = $signed({1'b0, cfg.noise_rate}) * stg_z_r;

  assign in_box = (stg_x_r >= cfg.box_min_x) && (stg_x_r <= cfg.box_max_x) &&
                  (stg_y_r >= cfg.box_min_y) && (stg_y_r <= cfg.box_max_y) &&
                  (stg_z_r >= cfg.box_min_z) && (stg_z_r <= cfg.box_max_z);

  always_comb begin
    push_item            = '0;
    push_item.kind       = stg_kind_r;
    push_item.pos_x      = stg_x_r;
    push_item.pos_y      = stg_y_r;
    push_item.pos_z      = stg_z_r;
    push_item.slot       = stg_slot_r;
    push_item.seed_red   = stg_color_r[11:0];
    push_item.seed_green = stg_color_r[23:12];
    push_item.seed_blue  = stg_color_r[35:24];
    push_item.in_box     = in_box;
    push_item.ph_x       = prod_x[23:8];
    // cos channel: shift the y phase by a quarter turn
    push_item.ph_y       = prod_y[23:8] + vcl_pkg::QUARTER_TURN;
    push_item.ph_z       = prod_z[23:8];
  end

endmodule

// ===== design/vcl_queue.sv =====
// Short FIFO that decouples the front end from the search engine.
// Depends on vcl_pkg.
module vcl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vcl_pkg::item_t   push_item,
  input  logic             pop,
  output vcl_pkg::item_t   head,
  output vcl_pkg::q_stat_t q_stat
);

  localparam int PW = (vcl_pkg::QDEPTH > 1) ? $clog2(vcl_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(vcl_pkg::QDEPTH + 1);

  vcl_pkg::item_t mem_r [vcl_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CW'(vcl_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(vcl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(vcl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/vcl_back.sv =====
// Back end: seed tables, sequential L1 nearest search, noise and output register.
// Depends on vcl_pkg.
module vcl_back #(
  parameter int MAX_SEEDS    = vcl_pkg::MAX_SEEDS_DEF,
  parameter int SINE_ENTRIES = vcl_pkg::SINE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vcl_pkg::cfg_t    cfg,
  input  vcl_pkg::item_t   head,
  input  vcl_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic [0:0]       out_tuser
);

  localparam int SEED_AW = $clog2(MAX_SEEDS);
  localparam int CNT_W   = $clog2(MAX_SEEDS + 1);
  localparam int NW      = (CNT_W > 8) ? CNT_W : 8;
  localparam int SIDX_W  = $clog2(SINE_ENTRIES);
  localparam int PROD_W  = 16 + SIDX_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_COLOR = 4'b0100,
    ST_SEND  = 4'b1000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [47:0] coord_mem [MAX_SEEDS];
  logic [35:0] color_mem [MAX_SEEDS];

  vcl_pkg::item_t item_r;
  logic [SEED_AW-1:0] iss_r;
  logic               iss_done_r;
  logic [SEED_AW-1:0] last_r;
  logic               v1_r;
  logic [SEED_AW-1:0] v1_idx_r;
  logic [47:0]        coord_rd_r;
  logic               v2_r;
  logic [SEED_AW-1:0] v2_idx_r;
  logic [vcl_pkg::DIST_W-1:0] dist_r;
  logic [vcl_pkg::DIST_W-1:0] best_d_r;
  logic [SEED_AW-1:0] best_r;
  logic [35:0]        color_rd_r;

  logic               issuing;
  logic               scan_end;
  logic               send;
  logic               load_hit;
  logic [SEED_AW+6:0] slot_ext;
  logic [SEED_AW-1:0] slot_addr;
  logic [NW-1:0]      n_raw;
  logic [NW-1:0]      n_sat;
  logic [vcl_pkg::DIST_W-1:0] l1_sum;
  logic signed [16:0] dx, dy, dz;
  logic [16:0]        ax, ay, az;

  logic signed [vcl_pkg::SIN_W-1:0] sine_rom [SINE_ENTRIES];
  logic [PROD_W-1:0] sp_x, sp_y, sp_z;
  logic [SIDX_W-1:0] sidx_x_r, sidx_y_r, sidx_z_r;
  logic signed [vcl_pkg::SIN_W-1:0] sin_x_r, sin_y_r, sin_z_r;

  logic               out_valid_r;
  logic [55:0]        out_data_r;
  logic               out_user_r;
  logic signed [13:0] res_red, res_green, res_blue;
  logic [SEED_AW+6:0] best_ext;

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    localparam longint unsigned T = (longint'(k) * 65536) / SINE_ENTRIES;
    assign sine_rom[k] = vcl_pkg::sine_value(T);
  end

  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;
  assign slot_ext = {{SEED_AW{1'b0}}, head.slot};
  assign slot_addr = slot_ext[SEED_AW-1:0];
  assign load_hit = pop && (head.kind == vcl_pkg::KIND_LOAD) &&
                    (32'(head.slot) < 32'(MAX_SEEDS));

  always_comb begin
    n_raw = NW'(cfg.seed_count);
    if (n_raw == '0) begin
      n_sat = NW'(1);
    end else if (n_raw > NW'(MAX_SEEDS)) begin
      n_sat = NW'(MAX_SEEDS);
    end else begin
      n_sat = n_raw;
    end
  end

  assign issuing  = (state_r == ST_SCAN) && !iss_done_r;
  assign scan_end = v2_r && (v2_idx_r == last_r);
  assign send     = (state_r == ST_SEND) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && head.kind == vcl_pkg::KIND_QUERY) begin
          state_nxt = head.in_box ? ST_SCAN : ST_SEND;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_COLOR;
        end
      end
      ST_COLOR: state_nxt = ST_SEND;
      ST_SEND: begin
        if (send) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // seed tables
  always_ff @(posedge clk) begin
    if (load_hit) begin
      coord_mem[slot_addr] <= {head.pos_z, head.pos_y, head.pos_x};
      color_mem[slot_addr] <= {head.seed_blue, head.seed_green, head.seed_red};
    end
    coord_rd_r <= coord_mem[iss_r];
    color_rd_r <= color_mem[best_r];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
  end

  // scan issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_done_r <= 1'b1;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
    end else begin
      if (pop) begin
        iss_done_r <= 1'b0;
      end else if (issuing && iss_r == last_r) begin
        iss_done_r <= 1'b1;
      end
      v1_r <= issuing;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      iss_r  <= '0;
      last_r <= SEED_AW'(n_sat - NW'(1));
    end else if (issuing && iss_r != last_r) begin
      iss_r <= iss_r + 1'b1;
    end
    v1_idx_r <= iss_r;
    v2_idx_r <= v1_idx_r;
  end

  assign dx = 17'(item_r.pos_x) - 17'($signed(coord_rd_r[15:0]));
  assign dy = 17'(item_r.pos_y) - 17'($signed(coord_rd_r[31:16]));
  assign dz = 17'(item_r.pos_z) - 17'($signed(coord_rd_r[47:32]));
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign az = dz[16] ? 17'(-dz) : 17'(dz);
  assign l1_sum = vcl_pkg::DIST_W'(ax) + vcl_pkg::DIST_W'(ay) + vcl_pkg::DIST_W'(az);

  // distance register, then running minimum; strict less keeps the lowest index
  always_ff @(posedge clk) begin
    dist_r <= l1_sum;
    if (pop) begin
      best_r <= '0;
    end else if (v2_r && (v2_idx_r == '0 || dist_r < best_d_r)) begin
      best_r   <= v2_idx_r;
      best_d_r <= dist_r;
    end
  end

  // noise lookup, settles while the scan runs
  assign sp_x = PROD_W'(item_r.ph_x) * PROD_W'(SINE_ENTRIES);
  assign sp_y = PROD_W'(item_r.ph_y) * PROD_W'(SINE_ENTRIES);
  assign sp_z = PROD_W'(item_r.ph_z) * PROD_W'(SINE_ENTRIES);

  always_ff @(posedge clk) begin
    sidx_x_r <= sp_x[16 +: SIDX_W];
    sidx_y_r <= sp_y[16 +: SIDX_W];
    sidx_z_r <= sp_z[16 +: SIDX_W];
    sin_x_r  <= sine_rom[sidx_x_r];
    sin_y_r  <= sine_rom[sidx_y_r];
    sin_z_r  <= sine_rom[sidx_z_r];
  end

  assign res_red   = $signed({2'b00, color_rd_r[11:0]})  + 14'(sin_x_r);
  assign res_green = $signed({2'b00, color_rd_r[23:12]}) + 14'(sin_y_r);
  assign res_blue  = $signed({2'b00, color_rd_r[35:24]}) + 14'(sin_z_r);
  assign best_ext  = {7'b0, best_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (send) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_user_r <= item_r.in_box;
      if (item_r.in_box) begin
        out_data_r <= {7'b0, res_blue, res_green, res_red, best_ext[6:0]};
      end else begin
        out_data_r <= {7'b0, vcl_pkg::OUTSIDE_COLOR, vcl_pkg::OUTSIDE_COLOR,
                       vcl_pkg::OUTSIDE_COLOR, 7'b0};
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

// ===== verif/voronoi_l1_color_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the L1 Voronoi color lookup core: mirrors the registers and the seed
// table from observed transfers, predicts every query result and compares it in order.
// Depends on vcl_pkg for the kind, register codes and output constants.
module voronoi_l1_color_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int SEEDS  = vcl_pkg::MAX_SEEDS_DEF;
  localparam int WAVE_N = vcl_pkg::SINE_ENTRIES_DEF;

  // odd polynomial for sin over a quarter turn, Q24 coefficients
  localparam longint unsigned K1 = 64'd26353589;
  localparam longint unsigned K3 = 64'd10837479;
  localparam longint unsigned K5 = 64'd1337020;
  localparam longint unsigned K7 = 64'd78547;

  typedef struct packed {
    logic               in_box;
    logic [6:0]         nearest;
    logic signed [13:0] red;
    logic signed [13:0] green;
    logic signed [13:0] blue;
  } color_t;

  logic signed [15:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [15:0]        rate;
  logic [7:0]         count;
  logic signed [15:0] seed_pos [SEEDS][3];
  logic [11:0]        seed_rgb [SEEDS][3];
  logic signed [9:0]  wave [WAVE_N];
  color_t             colors_due [$];

  // 0.1*sin in Q12 at entry k of the noise table
  function automatic logic signed [9:0] tenth_sine(int k);
    longint unsigned ang, quad, rem, arg, arg2, acc, prod;
    logic signed [9:0] mag;
    ang  = (longint'(k) * 65536) / WAVE_N;
    quad = (ang >> 14) & 3;
    rem  = ang & 16383;
    arg  = quad[0] ? (16384 - rem) : rem;
    arg2 = (arg * arg + 8192) >> 14;
    acc  = K5 - ((K7 * arg2) >> 14);
    acc  = K3 - ((acc * arg2) >> 14);
    acc  = K1 - ((acc * arg2) >> 14);
    prod = (acc * arg) >> 14;
    mag  = 10'((prod + 20480) / 40960);
    return quad[1] ? -mag : mag;
  endfunction

  initial begin
    for (int k = 0; k < WAVE_N; k++) begin
      wave[k] = tenth_sine(k);
    end
  end

  function automatic logic [15:0] phase_at(logic signed [15:0] c);
    longint prod;
    prod = longint'(rate) * longint'(c);
    return prod[23:8];
  endfunction

  function automatic int noise(logic [15:0] ph);
    return int'(wave[(int'(ph) * WAVE_N) >> 16]);
  endfunction

  function automatic int span(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic color_t lookup_color(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
    color_t res;
    int n, d_sum, best_dist, best;
    res = '0;
    res.in_box = (x >= lo_x) && (x <= hi_x) && (y >= lo_y) && (y <= hi_y) &&
                 (z >= lo_z) && (z <= hi_z);
    if (!res.in_box) begin
      res.red   = vcl_pkg::OUTSIDE_COLOR;
      res.green = vcl_pkg::OUTSIDE_COLOR;
      res.blue  = vcl_pkg::OUTSIDE_COLOR;
      return res;
    end
    // zero scans one seed, anything past the table scans the whole table
    n = (count == 0) ? 1 : ((int'(count) > SEEDS) ? SEEDS : int'(count));
    best = 0;
    best_dist = 32'h7fffffff;
    for (int i = 0; i < n; i++) begin
      d_sum = span(x, seed_pos[i][0]) + span(y, seed_pos[i][1]) + span(z, seed_pos[i][2]);
      if (d_sum < best_dist) begin
        best_dist = d_sum;
        best = i;
      end
    end
    res.nearest = 7'(best);
    res.red   = 14'(int'(seed_rgb[best][0]) + noise(phase_at(x)));
    res.green = 14'(int'(seed_rgb[best][1]) + noise(phase_at(y) + vcl_pkg::QUARTER_TURN));
    res.blue  = 14'(int'(seed_rgb[best][2]) + noise(phase_at(z)));
    return res;
  endfunction

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    color_t got, want;
    logic signed [15:0] px, py, pz;
    logic [6:0] slot;
    if (!rst_n) begin
      lo_x = 16'sd0;
      hi_x = 16'sd256;
      lo_y = 16'sd0;
      hi_y = 16'sd256;
      lo_z = 16'sd0;
      hi_z = 16'sd256;
      rate = 16'd4096;
      count = 8'd1;
      colors_due.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.in_box  = out_tuser[0];
        got.nearest = out_tdata[6:0];
        got.red     = out_tdata[20:7];
        got.green   = out_tdata[34:21];
        got.blue    = out_tdata[48:35];
        if (colors_due.size() == 0) begin
          $display("%0t: result transfer with nothing expected, expected none, actual %h",
                   $time, got);
          fail_count++;
        end else begin
          want = colors_due.pop_front();
          check_field("inside_res", want.in_box, got.in_box);
          check_field("nearest", want.nearest, got.nearest);
          check_field("out_red", want.red, got.red);
          check_field("out_green", want.green, got.green);
          check_field("out_blue", want.blue, got.blue);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vcl_pkg::CFG_BOX_MIN_X:  lo_x = cfg_data;
          vcl_pkg::CFG_BOX_MAX_X:  hi_x = cfg_data;
          vcl_pkg::CFG_BOX_MIN_Y:  lo_y = cfg_data;
          vcl_pkg::CFG_BOX_MAX_Y:  hi_y = cfg_data;
          vcl_pkg::CFG_BOX_MIN_Z:  lo_z = cfg_data;
          vcl_pkg::CFG_BOX_MAX_Z:  hi_z = cfg_data;
          vcl_pkg::CFG_NOISE_RATE: rate = cfg_data;
          vcl_pkg::CFG_SEED_COUNT: count = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        px = in_tdata[15:0];
        py = in_tdata[31:16];
        pz = in_tdata[47:32];
        slot = in_tdata[54:48];
        if (in_tuser[0] == vcl_pkg::KIND_LOAD) begin
          seed_pos[slot][0] = px;
          seed_pos[slot][1] = py;
          seed_pos[slot][2] = pz;
          seed_rgb[slot][0] = in_tdata[66:55];
          seed_rgb[slot][1] = in_tdata[78:67];
          seed_rgb[slot][2] = in_tdata[90:79];
        end else begin
          colors_due.insert(colors_due.size(), lookup_color(px, py, pz));
        end
      end
    end
    pending = colors_due.size();
  end

endmodule

// ===== verif/voronoi_l1_cell_color_lookup_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the L1 Voronoi color lookup testbench: clock, reset, stimulus and verdict.
// Depends on vcl_pkg, the core and the voronoi_l1_color_checker scoreboard.
module voronoi_l1_cell_color_lookup_core_tb;

  localparam int         RUN_ITEMS     = 700;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         SETTLE_CYCLES = 16;   // lets the last load reach the seed tables
  localparam int         DRAIN_CYCLES  = 200;  // longer than the slowest query
  localparam logic [3:0] CFG_SPARE     = 4'd12; // unmapped index, must be ignored

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], slot[54:48], seed_red[66:55],
  // seed_green[78:67], seed_blue[90:79], zero pad[95:91]
  logic [95:0] in_tdata;
  // kind[0]
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // nearest[6:0], out_red[20:7], out_green[34:21], out_blue[48:35], zero pad[55:49]
  logic [55:0] out_tdata;
  // inside_res[0]
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  int tx_max = 3;
  int rx_max = 3;
  int scan_len;                        // seeds a query scans under the current setting
  bit loaded [vcl_pkg::MAX_SEEDS_DEF];
  logic signed [15:0] seed_at [vcl_pkg::MAX_SEEDS_DEF][3];
  logic signed [15:0] box [6];         // shadow of the box registers, indexed by code

  voronoi_l1_cell_color_lookup_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  voronoi_l1_color_checker color_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run; the bound covers every item at its slowest with full stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: hold tready low for a random stall before each transfer.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(rx_max, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic int gap_limit();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 3;
      default: return 19;
    endcase
  endfunction

  // Present one item after a random gap, hold it until the transfer, then
  // leave valid high so back-to-back items need no extra edge.
  task automatic send_item(logic kind, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [6:0] slot, logic [11:0] r,
                           logic [11:0] g, logic [11:0] b);
    int gap;
    gap = $urandom_range(tx_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {5'd0, b, g, r, slot, z, y, x};
    in_tuser  <= kind;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
    if (kind == vcl_pkg::KIND_LOAD) begin
      loaded[slot]     = 1'b1;
      seed_at[slot][0] = x;
      seed_at[slot][1] = y;
      seed_at[slot][2] = z;
    end
  endtask

  // Query with noise on the fields that a query does not use.
  task automatic ask(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
    send_item(vcl_pkg::KIND_QUERY, x, y, z, 7'($urandom), 12'($urandom), 12'($urandom),
              12'($urandom));
  endtask

  // Coordinate on one axis, biased toward the box and its edges.
  function automatic logic [15:0] point_in(int axis);
    int lo, hi;
    lo = box[2 * axis];
    hi = box[2 * axis + 1];
    if (hi < lo) return 16'($urandom);
    case ($urandom_range(15, 0))
      0:       return 16'(lo);
      1:       return 16'(hi);
      2:       return 16'(lo - 1);
      3:       return 16'(hi + 1);
      default: return 16'(lo + $urandom_range(hi - lo, 0));
    endcase
  endfunction

  task automatic load_seed(logic [6:0] slot);
    logic [15:0] c [3];
    int pick, mode;
    mode = $urandom_range(9, 0);
    pick = $urandom_range(scan_len - 1, 0);
    for (int a = 0; a < 3; a++) begin
      if (mode == 0 && loaded[pick]) begin
        c[a] = seed_at[pick][a];         // duplicate point: forces a distance tie
      end else if (mode < 7) begin
        c[a] = point_in(a);
      end else begin
        c[a] = 16'($urandom);
      end
    end
    send_item(vcl_pkg::KIND_LOAD, c[0], c[1], c[2], slot, 12'($urandom), 12'($urandom),
              12'($urandom));
  endtask

  task automatic random_query();
    logic [15:0] c [3];
    int pick, mode;
    mode = $urandom_range(99, 0);
    pick = $urandom_range(scan_len - 1, 0);
    for (int a = 0; a < 3; a++) begin
      if (mode < 55) begin
        c[a] = point_in(a);
      end else if (mode < 85) begin
        c[a] = seed_at[pick][a] + 16'($urandom_range(64, 0)) - 16'd32;
      end else begin
        c[a] = 16'($urandom);
      end
    end
    ask(c[0], c[1], c[2]);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx <= vcl_pkg::CFG_BOX_MAX_Z) begin
      box[idx] = val;
    end else if (idx == vcl_pkg::CFG_SEED_COUNT) begin
      scan_len = (val[7:0] == 0) ? 1 :
                 ((int'(val[7:0]) > vcl_pkg::MAX_SEEDS_DEF) ? vcl_pkg::MAX_SEEDS_DEF :
                  int'(val[7:0]));
    end
  endtask

  // Drain, rewrite every register, then load any seed the new scan would read
  // before it was ever written.
  task automatic apply_setting(int min_x, int max_x, int min_y, int max_y, int min_z,
                               int max_z, logic [15:0] rate, logic [7:0] count);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(vcl_pkg::CFG_BOX_MIN_X, 16'(min_x));
    write_reg(vcl_pkg::CFG_BOX_MAX_X, 16'(max_x));
    write_reg(vcl_pkg::CFG_BOX_MIN_Y, 16'(min_y));
    write_reg(vcl_pkg::CFG_BOX_MAX_Y, 16'(max_y));
    write_reg(vcl_pkg::CFG_BOX_MIN_Z, 16'(min_z));
    write_reg(vcl_pkg::CFG_BOX_MAX_Z, 16'(max_z));
    write_reg(vcl_pkg::CFG_NOISE_RATE, rate);
    write_reg(vcl_pkg::CFG_SEED_COUNT, {8'd0, count});
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    tx_max = gap_limit();
    rx_max = gap_limit();
    for (int i = 0; i < scan_len; i++) begin
      if (!loaded[i]) load_seed(7'(i));
    end
  endtask

  initial begin
    int phase, batch;
    int lo [3];
    int hi [3];
    logic [15:0] rate_v;
    logic [7:0] count_v;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = vcl_pkg::KIND_LOAD;
    cfg_valid = 1'b0;
    cfg_index = vcl_pkg::CFG_BOX_MIN_X;
    cfg_data  = '0;
    scan_len  = 1;
    for (int a = 0; a < 3; a++) begin
      box[2 * a]     = 16'sd0;
      box[2 * a + 1] = 16'sd256;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset box, corners, each face just outside, exact seed hit.
    send_item(vcl_pkg::KIND_LOAD, 16'sd128, 16'sd128, 16'sd128, 7'd0, 12'd4095, 12'd0,
              12'd4095);
    ask(16'sd0, 16'sd0, 16'sd0);
    ask(16'sd256, 16'sd256, 16'sd256);
    ask(16'sd128, 16'sd128, 16'sd128);
    ask(16'sd257, 16'sd0, 16'sd0);
    ask(-16'sd1, 16'sd0, 16'sd0);
    ask(16'sd0, 16'sd257, 16'sd0);
    ask(16'sd0, -16'sd1, 16'sd0);
    ask(16'sd0, 16'sd0, 16'sd257);
    ask(16'sd0, 16'sd0, -16'sd1);
    // Seeds at both coordinate extremes and a duplicate of seed 0 for a tie.
    send_item(vcl_pkg::KIND_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 7'd1, 12'd0, 12'd4095,
              12'd0);
    send_item(vcl_pkg::KIND_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 7'd2, 12'd2048, 12'd1,
              12'd4094);
    send_item(vcl_pkg::KIND_LOAD, 16'sd128, 16'sd128, 16'sd128, 7'd127, 12'd0, 12'd0,
              12'd0);
    send_item(vcl_pkg::KIND_LOAD, 16'sd128, 16'sd128, 16'sd128, 7'd3, 12'd0, 12'd0, 12'd0);
    apply_setting(-32768, 32767, -32768, 32767, -32768, 32767, 16'hffff, 8'd4);
    ask(16'sh7fff, 16'sh7fff, 16'sh7fff);
    ask(16'sh8000, 16'sh8000, 16'sh8000);
    ask(16'sd128, 16'sd128, 16'sd128);
    ask(16'sd0, 16'sd0, 16'sd0);

    // Random phases, each under a fresh register setting.
    phase = 0;
    while (items_sent < RUN_ITEMS) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = int'($signed(16'($urandom)));
        if ($urandom_range(3, 0) != 0) begin
          hi[a] = lo[a] + $urandom_range(20000, 0);
          if (hi[a] > 32767) hi[a] = 32767;
        end else begin
          hi[a] = int'($signed(16'($urandom)));
        end
      end
      rate_v = 16'($urandom);
      case ($urandom_range(9, 0))
        0:       count_v = 8'($urandom_range(255, 65));
        1, 2:    count_v = 8'($urandom_range(64, 13));
        default: count_v = 8'($urandom_range(12, 1));
      endcase
      case (phase)
        // whole plane, fastest noise, count past the table
        0: apply_setting(-32768, 32767, -32768, 32767, -32768, 32767, 16'hffff, 8'd255);
        // single-point box, no noise, count of zero
        1: apply_setting(lo[0], lo[0], lo[1], lo[1], lo[2], lo[2], 16'd0, 8'd0);
        // empty box: min above max on every axis
        2: apply_setting(100, -100, 100, -100, 100, -100, rate_v, count_v);
        default: apply_setting(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], rate_v, count_v);
      endcase
      batch = $urandom_range(60, 20);
      repeat (batch) begin
        if ($urandom_range(99, 0) < 30) begin
          if ($urandom_range(4, 0) != 0) begin
            load_seed(7'($urandom_range(scan_len - 1, 0)));
          end else begin
            load_seed(7'($urandom_range(vcl_pkg::MAX_SEEDS_DEF - 1, 0)));
          end
        end else begin
          random_query();
        end
      end
      phase++;
    end

    // Wait out every expected result, then watch for strays.
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vcl_pkg.sv
design/vcl_front.sv
design/vcl_queue.sv
design/vcl_back.sv
design/voronoi_l1_cell_color_lookup_core.sv
verif/voronoi_l1_color_checker.sv
verif/voronoi_l1_cell_color_lookup_core_tb.sv
